// ===== hw/rtl/pidc_pkg.sv =====
package pidc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING = 3'd5;

    // field widths
    localparam int TARGET_W = 16;
    localparam int GAIN_W   = 16;
    localparam int DRIVE_W  = 14;

    // register reset values
    localparam logic [TARGET_W-1:0] TARGET_RESET  = 16'd2500;
    localparam logic [DRIVE_W-1:0]  CEILING_RESET = 14'd10000;

    // fixed point scale of all terms, and the remainder width it needs
    localparam int DIVISOR = 100;
    localparam int REM_W   = 7;

    // term lanes
    localparam int N_LANES = 3;
    localparam int LANE_P  = 0;
    localparam int LANE_I  = 1;
    localparam int LANE_D  = 2;

    typedef struct packed {
        logic [TARGET_W-1:0] target_value;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [DRIVE_W-1:0]  drive_floor;
        logic [DRIVE_W-1:0]  drive_ceiling;
    } t_cfg;

endpackage

// ===== hw/rtl/pid_controller_fixed_point.sv =====
// pipeline: input register, error register, product and sign-magnitude registers, the
//   divide-by-100 stages (five at the default widths), then the term sum and result registers
// throughput: one sample per cycle unless stalled, set by the error sum add/clamp loop
// a clear item takes one slot and gives no result
// reset: synchronous, active low; empties the pipeline, zeroes error sum and last error,
//   and loads the registers with their defaults
module pid_controller_fixed_point
    import pidc_pkg::*;
#(
    parameter int SUM_LIMIT    = 500000,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_mode,
    input  logic signed [SAMPLE_WIDTH-1:0] i_measured,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [DRIVE_W-1:0]             o_drive,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data
);

    localparam int ERR_W = ((SAMPLE_WIDTH > TARGET_W) ? SAMPLE_WIDTH : TARGET_W) + 1;
    localparam int SUM_W = $clog2(SUM_LIMIT + 1) + 1;
    localparam int MAG_W = (((ERR_W + 1) > SUM_W) ? (ERR_W + 1) : SUM_W) + GAIN_W + 1;

    t_cfg r_cfg;
    logic cfg_we;
    logic sum_clr;

    logic                          err_vld;
    logic                          err_stall;
    logic signed [ERR_W-1:0]       err_err;
    logic signed [SUM_W-1:0]       err_sum;
    logic signed [ERR_W:0]         err_diff;
    logic                          prd_vld;
    logic                          prd_stall;
    logic [N_LANES-1:0][MAG_W-1:0] prd_mag;
    logic [N_LANES-1:0]            prd_neg;
    logic                          div_vld;
    logic                          div_stall;
    logic [N_LANES-1:0][MAG_W-1:0] div_quo;
    logic [N_LANES-1:0]            div_neg;

    // register writes are taken at once
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        sum_clr = 1'b0;
        if (cfg_we) begin
            case (i_cfg_index) inside
                REG_GAIN_P, REG_GAIN_I, REG_GAIN_D: sum_clr = 1'b1;
                default:                            sum_clr = 1'b0;
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_value  <= TARGET_RESET;
            r_cfg.gain_p        <= '0;
            r_cfg.gain_i        <= '0;
            r_cfg.gain_d        <= '0;
            r_cfg.drive_floor   <= '0;
            r_cfg.drive_ceiling <= CEILING_RESET;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                REG_TARGET:  r_cfg.target_value  <= i_cfg_data[TARGET_W-1:0];
                REG_GAIN_P:  r_cfg.gain_p        <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:  r_cfg.gain_i        <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:  r_cfg.gain_d        <= i_cfg_data[GAIN_W-1:0];
                REG_FLOOR:   r_cfg.drive_floor   <= i_cfg_data[DRIVE_W-1:0];
                REG_CEILING: r_cfg.drive_ceiling <= i_cfg_data[DRIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // input register, error and state update
    pidc_error #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ERR_W        (ERR_W),
        .SUM_W        (SUM_W),
        .SUM_LIMIT    (SUM_LIMIT)
    ) u_error (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_sum_clr  (sum_clr),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_mode     (i_mode),
        .i_measured (i_measured),
        .o_valid    (err_vld),
        .i_stall    (err_stall),
        .o_err      (err_err),
        .o_sum      (err_sum),
        .o_diff     (err_diff)
    );

    // gain products
    pidc_product #(
        .ERR_W (ERR_W),
        .SUM_W (SUM_W),
        .MAG_W (MAG_W)
    ) u_product (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (err_vld),
        .o_stall (err_stall),
        .i_err   (err_err),
        .i_sum   (err_sum),
        .i_diff  (err_diff),
        .o_valid (prd_vld),
        .i_stall (prd_stall),
        .o_mag   (prd_mag),
        .o_neg   (prd_neg)
    );

    // truncating divide by the scale
    pidc_div100 #(
        .MAG_W (MAG_W)
    ) u_div100 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prd_vld),
        .o_stall (prd_stall),
        .i_mag   (prd_mag),
        .i_neg   (prd_neg),
        .o_valid (div_vld),
        .i_stall (div_stall),
        .o_quo   (div_quo),
        .o_neg   (div_neg)
    );

    // term sum, clamp and result register
    pidc_drive #(
        .MAG_W (MAG_W)
    ) u_drive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (div_vld),
        .o_stall (div_stall),
        .i_quo   (div_quo),
        .i_neg   (div_neg),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_drive (o_drive)
    );

endmodule

// ===== hw/rtl/pidc_error.sv =====
module pidc_error
    import pidc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ERR_W        = 17,
    parameter int SUM_W        = 20,
    parameter int SUM_LIMIT    = 500000
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cfg                           i_cfg,
    input  logic                           i_sum_clr,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_mode,
    input  logic signed [SAMPLE_WIDTH-1:0] i_measured,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [ERR_W-1:0]        o_err,
    output logic signed [SUM_W-1:0]        o_sum,
    output logic signed [ERR_W:0]          o_diff
);

    localparam int DIF_W = ERR_W + 1;
    localparam int ACC_W = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
    localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(SUM_LIMIT);
    localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI;

    logic                           r_in_vld;
    logic                           r_mode;
    logic signed [SAMPLE_WIDTH-1:0] r_meas;
    logic                           r_vld;
    logic signed [ERR_W-1:0]        r_err;
    logic signed [SUM_W-1:0]        r_sum_out;
    logic signed [DIF_W-1:0]        r_diff;
    logic signed [SUM_W-1:0]        r_sum;
    logic signed [ERR_W-1:0]        r_last;

    logic                    load_s1;
    logic                    load_in;
    logic                    move_in;
    logic signed [ERR_W-1:0] n_err;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] n_clamp;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [DIF_W-1:0] n_diff;

    // stage enables, a bubble in either stage is filled
    assign load_s1 = !r_vld || !i_stall;
    assign load_in = !r_in_vld || load_s1;
    assign move_in = r_in_vld && load_s1;
    assign o_stall = !load_in;

    // error, clamped error sum and error difference
    always_comb begin
        n_err = ERR_W'($signed(i_cfg.target_value)) - ERR_W'(r_meas);
        n_acc = ACC_W'(r_sum) + ACC_W'(n_err);
        if (n_acc > LIM_HI) begin
            n_clamp = LIM_HI;
        end else if (n_acc < LIM_LO) begin
            n_clamp = LIM_LO;
        end else begin
            n_clamp = n_acc;
        end
        n_sum  = n_clamp[SUM_W-1:0];
        n_diff = DIF_W'(n_err) - DIF_W'(r_last);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (load_in) begin
            r_in_vld <= i_valid;
        end
        if (load_in && i_valid) begin
            r_mode <= i_mode;
            r_meas <= i_measured;
        end
    end

    // controller state, a clear item empties it, a gain write clears the error sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_last <= '0;
        end else if (i_sum_clr) begin
            r_sum <= '0;
        end else if (move_in && r_mode) begin
            r_sum  <= '0;
            r_last <= '0;
        end else if (move_in) begin
            r_sum  <= n_sum;
            r_last <= n_err;
        end
    end

    // error stage register, clear items end here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load_s1) begin
            r_vld <= move_in && !r_mode;
        end
        if (move_in) begin
            r_err     <= n_err;
            r_sum_out <= n_sum;
            r_diff    <= n_diff;
        end
    end

    assign o_valid = r_vld;
    assign o_err   = r_err;
    assign o_sum   = r_sum_out;
    assign o_diff  = r_diff;

endmodule

// ===== hw/rtl/pidc_product.sv =====
module pidc_product
    import pidc_pkg::*;
#(
    parameter int ERR_W = 17,
    parameter int SUM_W = 20,
    parameter int MAG_W = 37
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_cfg                              i_cfg,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [ERR_W-1:0]           i_err,
    input  logic signed [SUM_W-1:0]           i_sum,
    input  logic signed [ERR_W:0]             i_diff,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [N_LANES-1:0][MAG_W-1:0]     o_mag,
    output logic [N_LANES-1:0]                o_neg
);

    localparam int DIF_W = ERR_W + 1;
    localparam int P_W   = ERR_W + GAIN_W + 1;
    localparam int I_W   = SUM_W + GAIN_W + 1;
    localparam int D_W   = DIF_W + GAIN_W + 1;

    logic                 r_a_vld;
    logic signed [P_W-1:0] r_p;
    logic signed [I_W-1:0] r_i;
    logic signed [D_W-1:0] r_d;
    logic                  r_b_vld;
    logic [N_LANES-1:0][MAG_W-1:0] r_mag;
    logic [N_LANES-1:0]            r_neg;

    logic                  load_a;
    logic                  load_b;
    logic signed [P_W-1:0] n_p;
    logic signed [I_W-1:0] n_i;
    logic signed [D_W-1:0] n_d;
    logic signed [N_LANES-1:0][MAG_W-1:0] n_ext;
    logic [N_LANES-1:0][MAG_W-1:0]        n_mag;
    logic [N_LANES-1:0]                   n_neg;

    assign load_b  = !r_b_vld || !i_stall;
    assign load_a  = !r_a_vld || load_b;
    assign o_stall = !load_a;

    // gain times value, one multiplier per term
    always_comb begin
        n_p = $signed({1'b0, i_cfg.gain_p}) * i_err;
        n_i = $signed({1'b0, i_cfg.gain_i}) * i_sum;
        n_d = $signed({1'b0, i_cfg.gain_d}) * i_diff;
    end

    // split each product into sign and magnitude
    always_comb begin
        n_ext[LANE_P] = MAG_W'(r_p);
        n_ext[LANE_I] = MAG_W'(r_i);
        n_ext[LANE_D] = MAG_W'(r_d);
        for (int l = 0; l < N_LANES; l++) begin
            n_neg[l] = n_ext[l][MAG_W-1];
            n_mag[l] = n_neg[l] ? (~n_ext[l] + MAG_W'(1)) : n_ext[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (load_a) begin
            r_a_vld <= i_valid;
        end
        if (load_a && i_valid) begin
            r_p <= n_p;
            r_i <= n_i;
            r_d <= n_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (load_b) begin
            r_b_vld <= r_a_vld;
        end
        if (load_b && r_a_vld) begin
            r_mag <= n_mag;
            r_neg <= n_neg;
        end
    end

    assign o_valid = r_b_vld;
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;

endmodule

// ===== hw/rtl/pidc_div100.sv =====
module pidc_div100
    import pidc_pkg::*;
#(
    parameter int MAG_W = 37
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [N_LANES-1:0][MAG_W-1:0] i_mag,
    input  logic [N_LANES-1:0]            i_neg,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [N_LANES-1:0][MAG_W-1:0] o_quo,
    output logic [N_LANES-1:0]            o_neg
);

    // division by the scale, one eight-bit quotient digit per stage
    localparam int DIGIT_BITS = 8;
    localparam int NSTG       = (MAG_W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PW         = NSTG * DIGIT_BITS;

    // partial dividend of one digit, always below the scale times 256
    localparam int T_W    = REM_W + DIGIT_BITS;
    localparam int PROD_W = 2 * T_W;
    // reciprocal of the scale, exact for every partial dividend below 2**21 / 48
    localparam int               RCP_SH = 21;
    localparam logic [T_W-1:0]   RCP    = T_W'((2**RCP_SH + DIVISOR - 1) / DIVISOR);

    function automatic logic [REM_W+PW-1:0] div_stage(
        input logic [PW-1:0]    w_in,
        input logic [REM_W-1:0] r_in
    );
        logic [T_W-1:0]        t;
        logic [PROD_W-1:0]     prod;
        logic [DIGIT_BITS-1:0] q;
        logic [T_W-1:0]        back;
        t    = {r_in, w_in[PW-1 -: DIGIT_BITS]};
        prod = PROD_W'(t) * PROD_W'(RCP);
        q    = prod[RCP_SH +: DIGIT_BITS];
        back = t - T_W'(q) * T_W'(DIVISOR);
        return {back[REM_W-1:0], w_in[PW-DIGIT_BITS-1:0], q};
    endfunction

    logic                            r_vld  [NSTG];
    logic [N_LANES-1:0][PW-1:0]      r_work [NSTG];
    logic [N_LANES-1:0][REM_W-1:0]   r_rem  [NSTG-1];
    logic [N_LANES-1:0]              r_neg  [NSTG];

    logic [NSTG-1:0]                 load;
    logic [NSTG-1:0]                 vld_in;
    logic [N_LANES-1:0][PW-1:0]      w_in   [NSTG];
    logic [N_LANES-1:0][REM_W-1:0]   rem_in [NSTG];
    logic [N_LANES-1:0]              neg_in [NSTG];
    logic [N_LANES-1:0][PW-1:0]      n_work [NSTG];
    logic [N_LANES-1:0][REM_W-1:0]   n_rem  [NSTG];

    // stage enables from the output back
    always_comb begin
        load[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            load[k] = !r_vld[k] || load[k+1];
        end
    end
    assign o_stall = !load[0];

    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_stage
            // stage operands
            if (k == 0) begin : g_first
                assign vld_in[0] = i_valid;
                assign neg_in[0] = i_neg;
                assign rem_in[0] = '0;
                always_comb begin
                    for (int l = 0; l < N_LANES; l++) begin
                        w_in[0][l] = PW'(i_mag[l]);
                    end
                end
            end else begin : g_next
                assign vld_in[k] = r_vld[k-1];
                assign neg_in[k] = r_neg[k-1];
                assign rem_in[k] = r_rem[k-1];
                assign w_in[k]   = r_work[k-1];
            end

            // one digit of the quotient per lane
            always_comb begin
                for (int l = 0; l < N_LANES; l++) begin
                    {n_rem[k][l], n_work[k][l]} = div_stage(w_in[k][l], rem_in[k][l]);
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (load[k]) begin
                    r_vld[k] <= vld_in[k];
                end
                if (load[k] && vld_in[k]) begin
                    r_work[k] <= n_work[k];
                    r_neg[k]  <= neg_in[k];
                end
            end

            // the remainder travels to the next stage only
            if (k < NSTG - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (load[k] && vld_in[k]) begin
                        r_rem[k] <= n_rem[k];
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[NSTG-1];
    assign o_neg   = r_neg[NSTG-1];
    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            o_quo[l] = r_work[NSTG-1][l][MAG_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/pidc_drive.sv =====
module pidc_drive
    import pidc_pkg::*;
#(
    parameter int MAG_W = 37
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [N_LANES-1:0][MAG_W-1:0] i_quo,
    input  logic [N_LANES-1:0]            i_neg,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [DRIVE_W-1:0]            o_drive
);

    localparam int T_W = MAG_W + 2;

    logic                   r_a_vld;
    logic signed [T_W-1:0]  r_total;
    logic                   r_b_vld;
    logic [DRIVE_W-1:0]     r_drive;

    logic                   load_a;
    logic                   load_b;
    logic signed [N_LANES-1:0][MAG_W-1:0] n_term;
    logic signed [T_W-1:0]  n_total;
    logic signed [T_W-1:0]  n_ceil;
    logic signed [T_W-1:0]  n_floor;
    logic signed [T_W-1:0]  n_hi;
    logic signed [T_W-1:0]  n_lo;

    assign load_b  = !r_b_vld || !i_stall;
    assign load_a  = !r_a_vld || load_b;
    assign o_stall = !load_a;

    // restore the signs and add the three terms
    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            n_term[l] = i_neg[l] ? (~i_quo[l] + MAG_W'(1)) : i_quo[l];
        end
        n_total = T_W'($signed(n_term[LANE_P])) + T_W'($signed(n_term[LANE_I]))
                + T_W'($signed(n_term[LANE_D]));
    end

    // ceiling first, then floor, so the floor wins when they cross
    always_comb begin
        n_ceil  = T_W'($signed({1'b0, i_cfg.drive_ceiling}));
        n_floor = T_W'($signed({1'b0, i_cfg.drive_floor}));
        n_hi    = (r_total > n_ceil) ? n_ceil : r_total;
        n_lo    = (n_hi < n_floor) ? n_floor : n_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (load_a) begin
            r_a_vld <= i_valid;
        end
        if (load_a && i_valid) begin
            r_total <= n_total;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (load_b) begin
            r_b_vld <= r_a_vld;
        end
        if (load_b && r_a_vld) begin
            r_drive <= n_lo[DRIVE_W-1:0];
        end
    end

    assign o_valid = r_b_vld;
    assign o_drive = r_drive;

endmodule

// ===== dv/pid_controller_checker.sv =====
`timescale 1ns / 100ps

// watches the sample, drive and register channels, predicts every drive value
// and compares it with what the controller delivers
module pid_controller_checker
    import pidc_pkg::*;
#(
    parameter int SUM_LIMIT = 500000
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic                   i_mode,
    input  logic signed [15:0]     i_measured,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [DRIVE_W-1:0]     i_drive,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_pending,
    output int                     o_fail_count
);

    // shadow registers and controller state
    t_cfg               regs;
    logic signed [19:0] err_sum;
    logic signed [17:0] prev_err;

    // drive values still owed by the controller, oldest first
    logic [DRIVE_W-1:0] drive_queue[$];
    int                 fail_count = 0;

    // one compute step: error, clamped error sum, three terms, output clamp
    function automatic logic [DRIVE_W-1:0] next_drive(input logic signed [15:0] sample);
        longint err;
        longint sum;
        longint p_term;
        longint i_term;
        longint d_term;
        longint total;
        err = longint'($signed(regs.target_value)) - longint'(sample);
        sum = longint'(err_sum) + err;
        if (sum > SUM_LIMIT) sum = SUM_LIMIT;
        if (sum < -SUM_LIMIT) sum = -SUM_LIMIT;
        // signed 64-bit division truncates toward zero
        p_term = longint'(regs.gain_p) * err / DIVISOR;
        i_term = longint'(regs.gain_i) * sum / DIVISOR;
        d_term = longint'(regs.gain_d) * (err - longint'(prev_err)) / DIVISOR;
        err_sum  = sum[19:0];
        prev_err = err[17:0];
        total = p_term + i_term + d_term;
        // ceiling first, floor last, so the floor wins when they cross
        if (total > longint'(regs.drive_ceiling)) total = longint'(regs.drive_ceiling);
        if (total < longint'(regs.drive_floor)) total = longint'(regs.drive_floor);
        return total[DRIVE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [DRIVE_W-1:0] want;
        if (!i_rst_n) begin
            regs.target_value  = TARGET_RESET;
            regs.gain_p        = '0;
            regs.gain_i        = '0;
            regs.gain_d        = '0;
            regs.drive_floor   = '0;
            regs.drive_ceiling = CEILING_RESET;
            err_sum            = '0;
            prev_err           = '0;
            drive_queue.delete();
        end else begin
            // register write; any gain write clears the error sum
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_TARGET: regs.target_value = i_cfg_data;
                    REG_GAIN_P: begin
                        regs.gain_p = i_cfg_data;
                        err_sum     = '0;
                    end
                    REG_GAIN_I: begin
                        regs.gain_i = i_cfg_data;
                        err_sum     = '0;
                    end
                    REG_GAIN_D: begin
                        regs.gain_d = i_cfg_data;
                        err_sum     = '0;
                    end
                    REG_FLOOR:   regs.drive_floor   = i_cfg_data[DRIVE_W-1:0];
                    REG_CEILING: regs.drive_ceiling = i_cfg_data[DRIVE_W-1:0];
                    default: ;
                endcase
            end

            // drive transfer is compared before this edge's sample is queued
            if (i_out_valid && !i_out_stall) begin
                if (drive_queue.size() == 0) begin
                    $display("%0t: drive %0d arrived with none expected", $time, i_drive);
                    fail_count++;
                end else begin
                    want = drive_queue.pop_front();
                    if (want !== i_drive) begin
                        $display("%0t: drive mismatch, expected %0d, actual %0d",
                                 $time, want, i_drive);
                        fail_count++;
                    end
                end
            end

            // sample transfer: clear item or compute item
            if (i_in_valid && !i_in_stall) begin
                if (i_mode) begin
                    err_sum  = '0;
                    prev_err = '0;
                end else begin
                    drive_queue.push_back(next_drive(i_measured));
                end
            end
        end
        o_pending    <= drive_queue.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== dv/pid_controller_fixed_point_test.sv =====
`timescale 1ns / 100ps

module pid_controller_fixed_point_test;
    import pidc_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int IDLE_PCT     = 38;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 116;
    localparam int TIMEOUT_NS   = 2_000_000;

    // indexes outside the register map
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_mode      = 1'b0;
    logic signed [15:0]    i_measured  = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [DRIVE_W-1:0]    o_drive;
    logic                  o_cfg_ready;

    int pending;
    int fail_count;
    int target_now = 2500;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_go    = 1'b0;

    pid_controller_fixed_point dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_measured  (i_measured),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_drive     (o_drive),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pid_controller_checker drive_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_measured   (i_measured),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_drive      (o_drive),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // drive receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_go = 1'b0;
            end
            i_out_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // hard stop
    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // wait until every drive is in, then let the pipeline drain clear items
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_in_valid <= 1'b0;
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int tgt, input int gp, input int gi, input int gd,
                              input int lo, input int hi);
        write_reg(REG_TARGET, tgt);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_FLOOR, lo);
        write_reg(REG_CEILING, hi);
        target_now = tgt;
    endtask

    // one sample transfer, with a random gap ahead of it
    task automatic send_item(input bit mode, input int sample);
        int gap = 0;
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_measured <= sample[15:0];
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // mostly samples near the setpoint, some noise, extremes and clears
    task automatic send_random(input int span);
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            send_item(1'b1, $urandom());
        end else if (pick < 25) begin
            send_item(1'b0, $urandom());
        end else if (pick < 32) begin
            case ($urandom_range(3))
                0: send_item(1'b0, 32767);
                1: send_item(1'b0, -32768);
                2: send_item(1'b0, 0);
                default: send_item(1'b0, -1);
            endcase
        end else begin
            send_item(1'b0, target_now + int'($urandom_range(2 * span)) - span);
        end
    endtask

    initial begin
        int tgt;
        int gp;
        int gi;
        int gd;
        int lo;
        int hi;
        int span;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: all gains zero
        send_item(1'b0, 0);

        // proportional only, across the sample range
        write_reg(REG_GAIN_P, 100);
        send_item(1'b0, 32767);
        send_item(1'b0, -32768);
        send_item(1'b0, 2500);
        send_item(1'b0, 2400);
        send_item(1'b0, -1);

        // integral and derivative, with a clear item in between
        write_reg(REG_GAIN_I, 100);
        write_reg(REG_GAIN_D, 100);
        send_item(1'b0, 2000);
        send_item(1'b0, 2600);
        send_item(1'b1, -1);
        send_item(1'b0, 2000);

        // floor above ceiling
        write_reg(REG_FLOOR, 9000);
        write_reg(REG_CEILING, 1000);
        send_item(1'b0, 2500);
        send_item(1'b0, -32768);

        // largest gains, ceiling beyond the nominal range
        set_config(32767, 65535, 65535, 65535, 0, 16383);
        send_item(1'b0, -32768);
        send_item(1'b0, -32768);
        set_config(-32768, 65535, 65535, 65535, 0, 10000);
        send_item(1'b0, 32767);
        send_item(1'b0, 32767);
        send_item(1'b0, 32767);

        // writes to unmapped indexes change nothing
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        send_item(1'b0, 2500);

        // random phases, each with its own register setting
        for (int k = 0; k < PHASES; k++) begin
            tgt  = int'($urandom_range(15000)) - 5000;
            gp   = $urandom_range(400);
            gi   = $urandom_range(20);
            gd   = $urandom_range(200);
            lo   = $urandom_range(3000);
            hi   = $urandom_range(10000, 6000);
            span = 300;
            case (k)
                1: begin
                    tgt  = 32767;
                    span = 2000;
                end
                2: tgt = -32768;
                3: begin
                    gp = 65535;
                    gi = 65535;
                    gd = 65535;
                end
                5: begin
                    gp = $urandom();
                    gi = $urandom();
                    gd = $urandom();
                    lo = $urandom();
                    hi = $urandom();
                end
                6: begin
                    lo = 0;
                    hi = 16383;
                end
                7: begin
                    lo = 9000;
                    hi = 1000;
                end
                default: ;
            endcase
            set_config(tgt, gp, gi, gd, lo, hi);

            // phase 2 fills the pipeline against a held receiver,
            // phase 4 runs with no idling on either side
            tx_idle_on = (k != 2) && (k != 4);
            rx_idle_on = (k != 4);
            if (k == 2) hold_go = 1'b1;
            repeat (PHASE_ITEMS) send_random(span);
            tx_idle_on = 1'b1;
            rx_idle_on = 1'b1;
        end

        i_in_valid <= 1'b0;
        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_error.sv
hw/rtl/pidc_product.sv
hw/rtl/pidc_div100.sv
hw/rtl/pidc_drive.sv
hw/rtl/pid_controller_fixed_point.sv
dv/pid_controller_checker.sv
dv/pid_controller_fixed_point_test.sv
